>>> sv/qes_pkg.sv
`timescale 1ns / 1ps
package qes_pkg;

  localparam int HISTORY_DEPTH = 5;

  localparam int DPC_W   = 24;
  localparam int TMO_W   = 16;
  localparam int MAXS_W  = 16;
  localparam int TIME_W  = 32;
  localparam int POS_W   = 32;
  localparam int SPEED_W = 32;
  localparam int DIST_W  = 56;
  localparam int DIR_W   = 2;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 2;

  // Speed numerator: distance_per_count * (depth + 1) * 1000, then scaled down by 256.
  localparam int SPEED_K = (HISTORY_DEPTH + 1) * 1000;
  localparam int K_W     = $clog2(SPEED_K + 1);
  localparam int NUM_W   = DPC_W + K_W;
  localparam int SPEED_FRAC = 8;
  localparam int QUO_W   = NUM_W - SPEED_FRAC;
  localparam int SUM_W   = TIME_W + $clog2(HISTORY_DEPTH + 1);
  localparam int DCNT_W  = $clog2(QUO_W + 1);

  localparam int MS_PER_S = 1000;
  localparam int LHS_W    = DPC_W + $clog2(MS_PER_S + 1);
  localparam int RHS_W    = MAXS_W + TIME_W;
  localparam int RHS_LIM_W = 20;
  localparam int DPC_FRAC = 16;

  localparam logic [1:0] MODE_EDGE  = 2'd0;
  localparam logic [1:0] MODE_POLL  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DPC     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXS    = 2'd3;

  localparam logic [DPC_W-1:0]  DPC_RESET  = 24'd65536;
  localparam logic [TMO_W-1:0]  TMO_RESET  = 16'd100;
  localparam logic [MAXS_W-1:0] MAXS_RESET = 16'd100;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic apply_edge;
    logic apply_poll;
    logic apply_clear;
    logic speed_zero;
    logic div_start;
    logic speed_load;
    logic dist_calc;
    logic out_load;
  } qes_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       glitch;
    logic       div_zero;
    logic       div_done;
    logic       out_free;
  } qes_stat_t;

endpackage

>>> sv/qes_div.sv
`timescale 1ns / 1ps
module qes_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [qes_pkg::QUO_W-1:0]    dividend_i,
  input  logic [qes_pkg::SUM_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [qes_pkg::QUO_W-1:0]    quotient_o
);
  import qes_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DCNT_W-1:0]   cnt_q, cnt_d;
  logic [QUO_W-1:0]    quo_q, quo_d;
  logic [SUM_W-1:0]    rem_q, rem_d;
  logic [SUM_W-1:0]    dvs_q, dvs_d;
  logic [SUM_W:0]      trial;

  // Restoring division, one quotient bit a cycle. The dividend shifts out of the
  // top of quo_q while quotient bits shift in at the bottom.
  assign trial = {rem_q, quo_q[QUO_W-1]} - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(QUO_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial[SUM_W]) begin
        rem_d = {rem_q[SUM_W-2:0], quo_q[QUO_W-1]};
        quo_d = {quo_q[QUO_W-2:0], 1'b0};
      end else begin
        rem_d = trial[SUM_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> sv/qes_datapath.sv
`timescale 1ns / 1ps
module qes_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [qes_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [qes_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic [1:0]                          mode_i,
  input  logic [qes_pkg::TIME_W-1:0]          time_ms_i,
  input  logic                                pin_a_level_i,
  input  logic                                pin_b_level_i,
  input  logic                                edge_channel_i,
  input  qes_pkg::qes_cmd_t                   cmd_i,
  output qes_pkg::qes_stat_t                  stat_o,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic                                edge_accepted_o,
  output logic signed [qes_pkg::POS_W-1:0]    position_count_o,
  output logic signed [qes_pkg::SPEED_W-1:0]  speed_value_o,
  output logic signed [qes_pkg::DIR_W-1:0]    motion_direction_o,
  output logic                                is_stopped_o,
  output logic signed [qes_pkg::DIST_W-1:0]   distance_value_o
);
  import qes_pkg::*;

  // Configuration.
  logic [DPC_W-1:0]  dpc_q;
  logic [TMO_W-1:0]  tmo_q;
  logic              invert_q;
  logic [MAXS_W-1:0] maxs_q;

  // Block state.
  logic [POS_W-1:0]   count_q;
  logic [SPEED_W-1:0] speed_q;
  logic [TIME_W-1:0]  last_q;
  logic [TIME_W-1:0]  hist_q [HISTORY_DEPTH];
  logic [SUM_W-1:0]   hist_sum_q;

  // Per-item working registers.
  logic [1:0]         mode_q;
  logic [TIME_W-1:0]  time_q;
  logic [TIME_W-1:0]  interval_q;
  logic               dir_q;
  logic               acc_q;
  logic [RHS_W-1:0]   rhs_q;
  logic [LHS_W-1:0]   lhs_q;
  logic [SUM_W-1:0]   sum_q;
  logic [QUO_W-1:0]   num_q;
  logic [DIST_W-1:0]  dist_q;

  logic               out_valid_q;
  logic               out_acc_q;
  logic [POS_W-1:0]   out_pos_q;
  logic [SPEED_W-1:0] out_speed_q;
  logic [DIR_W-1:0]   out_dir_q;
  logic               out_stop_q;
  logic [DIST_W-1:0]  out_dist_q;

  logic [NUM_W-1:0]   num_full;
  logic [DIST_W-1:0]  dist_full;
  logic [QUO_W-1:0]   quotient;
  logic               div_done;
  logic               poll_hit;
  logic               up;
  logic               glitch;

  assign num_full = NUM_W'(dpc_q) * NUM_W'(SPEED_K);
  assign dist_full = ($signed(count_q) * $signed({1'b0, dpc_q}));
  assign poll_hit = interval_q >= TIME_W'(tmo_q);
  assign up       = dir_q ^ invert_q;

  // A fast product beyond the limit can never trip the check, so only its low bits are compared.
  assign glitch = (rhs_q[RHS_W-1:RHS_LIM_W] == '0) &&
                  ((LHS_W + 2)'(lhs_q) > {rhs_q[RHS_LIM_W-1:0], {DPC_FRAC{1'b0}}});

  assign stat_o.mode     = mode_q;
  assign stat_o.glitch   = glitch;
  assign stat_o.div_zero = (dpc_q == '0) || (sum_q == '0);
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  qes_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_q),
    .divisor_i  (sum_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpc_q    <= DPC_RESET;
      tmo_q    <= TMO_RESET;
      invert_q <= 1'b0;
      maxs_q   <= MAXS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DPC:     dpc_q    <= cfg_data_i[DPC_W-1:0];
        CFG_TIMEOUT: tmo_q    <= cfg_data_i[TMO_W-1:0];
        CFG_INVERT:  invert_q <= cfg_data_i[0];
        CFG_MAXS:    maxs_q   <= cfg_data_i[MAXS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      speed_q    <= '0;
      last_q     <= '0;
      hist_sum_q <= '0;
      acc_q      <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load_in) begin
        acc_q <= 1'b0;
      end
      if (cmd_i.apply_edge) begin
        acc_q      <= 1'b1;
        last_q     <= time_q;
        hist_sum_q <= sum_q - SUM_W'(hist_q[HISTORY_DEPTH-1]);
        for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
          hist_q[i] <= hist_q[i-1];
        end
        hist_q[0] <= interval_q;
        count_q   <= up ? count_q + 1'b1 : count_q - 1'b1;
      end
      if (cmd_i.apply_poll && poll_hit) begin
        speed_q <= '0;
        last_q  <= time_q - TIME_W'(tmo_q);
      end
      if (cmd_i.apply_clear) begin
        count_q <= '0;
        speed_q <= '0;
      end
      if (cmd_i.speed_zero) begin
        speed_q <= '0;
      end
      if (cmd_i.speed_load) begin
        speed_q <= up ? SPEED_W'(quotient) : '0 - SPEED_W'(quotient);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q     <= mode_i;
      time_q     <= time_ms_i;
      interval_q <= time_ms_i - last_q;
      dir_q      <= pin_a_level_i ^ pin_b_level_i ^ edge_channel_i;
    end
    if (cmd_i.mul) begin
      rhs_q <= RHS_W'(maxs_q) * RHS_W'(interval_q);
      lhs_q <= LHS_W'(dpc_q) * LHS_W'(MS_PER_S);
      sum_q <= hist_sum_q + SUM_W'(interval_q);
      num_q <= num_full[NUM_W-1:SPEED_FRAC];
    end
    if (cmd_i.dist_calc) begin
      dist_q <= dist_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_acc_q   <= acc_q;
      out_pos_q   <= count_q;
      out_speed_q <= speed_q;
      out_stop_q  <= (speed_q == '0);
      out_dist_q  <= dist_q;
      if (speed_q == '0) begin
        out_dir_q <= 2'b00;
      end else if (speed_q[SPEED_W-1]) begin
        out_dir_q <= 2'b11;
      end else begin
        out_dir_q <= 2'b01;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign edge_accepted_o    = out_acc_q;
  assign position_count_o   = $signed(out_pos_q);
  assign speed_value_o      = $signed(out_speed_q);
  assign motion_direction_o = $signed(out_dir_q);
  assign is_stopped_o       = out_stop_q;
  assign distance_value_o   = $signed(out_dist_q);

endmodule

>>> sv/qes_ctrl.sv
`timescale 1ns / 1ps
module qes_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qes_pkg::qes_stat_t  stat_i,
  output qes_pkg::qes_cmd_t   cmd_o
);
  import qes_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SPEED = 3'd4;
  localparam logic [2:0] S_DIST  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        state_d = S_DIST;
        case (stat_i.mode)
          MODE_EDGE: begin
            if (!stat_i.glitch) begin
              cmd_o.apply_edge = 1'b1;
              if (stat_i.div_zero) begin
                cmd_o.speed_zero = 1'b1;
              end else begin
                cmd_o.div_start = 1'b1;
                state_d         = S_DIV;
              end
            end
          end
          MODE_POLL:  cmd_o.apply_poll  = 1'b1;
          MODE_CLEAR: cmd_o.apply_clear = 1'b1;
          default: ;
        endcase
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_SPEED;
        end
      end
      S_SPEED: begin
        cmd_o.speed_load = 1'b1;
        state_d          = S_DIST;
      end
      S_DIST: begin
        cmd_o.dist_calc = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> sv/quadrature_encoder_speed.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in       input      in_valid_i/in_stall_o   mode, time_ms, pin levels, edge_channel
// out      output     out_valid_o/out_stall_i edge_accepted, position, speed, direction,
//                                              stopped flag, distance
// cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// An edge that passes the glitch check, with nonzero distance per count and interval sum,
// runs the bit-serial divider for the speed (one quotient bit a cycle, 29 bits) in state DIV.
// Polls, clears and other edges go from CHECK straight to DIST. One item is in work at a time.
// A finished result waits in the output register while the next item is taken in.
// Reset is asynchronous and active low; it restores the default configuration and
// clears count, speed, last edge time and interval history at once.
module quadrature_encoder_speed (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [qes_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [qes_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          mode_i,
  input  logic [qes_pkg::TIME_W-1:0]          time_ms_i,
  input  logic                                pin_a_level_i,
  input  logic                                pin_b_level_i,
  input  logic                                edge_channel_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                edge_accepted_o,
  output logic signed [qes_pkg::POS_W-1:0]    position_count_o,
  output logic signed [qes_pkg::SPEED_W-1:0]  speed_value_o,
  output logic signed [qes_pkg::DIR_W-1:0]    motion_direction_o,
  output logic                                is_stopped_o,
  output logic signed [qes_pkg::DIST_W-1:0]   distance_value_o
);
  import qes_pkg::*;

  qes_cmd_t  cmd;
  qes_stat_t stat;

  qes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  qes_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .mode_i             (mode_i),
    .time_ms_i          (time_ms_i),
    .pin_a_level_i      (pin_a_level_i),
    .pin_b_level_i      (pin_b_level_i),
    .edge_channel_i     (edge_channel_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .edge_accepted_o    (edge_accepted_o),
    .position_count_o   (position_count_o),
    .speed_value_o      (speed_value_o),
    .motion_direction_o (motion_direction_o),
    .is_stopped_o       (is_stopped_o),
    .distance_value_o   (distance_value_o)
  );

endmodule

>>> sv/qes_checker.sv
`timescale 1ns / 1ps
module qes_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                edge_accepted_o,
  input logic signed [qes_pkg::POS_W-1:0]    position_count_o,
  input logic signed [qes_pkg::SPEED_W-1:0]  speed_value_o,
  input logic signed [qes_pkg::DIR_W-1:0]    motion_direction_o,
  input logic                                is_stopped_o
);
  import qes_pkg::*;

  // Only one item is in work, so an accepted item closes the input at once.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open in the cycle after an item was taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(speed_value_o) &&
                                   $stable(position_count_o) && $stable(edge_accepted_o))
    else $error("stalled result changed");

  a_stop_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> is_stopped_o == (speed_value_o == '0))
    else $error("stopped flag disagrees with speed");

  a_dir_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (speed_value_o > 0 && motion_direction_o == 2'sd1) ||
                    (speed_value_o < 0 && motion_direction_o == -2'sd1) ||
                    (speed_value_o == 0 && motion_direction_o == 2'sd0))
    else $error("direction disagrees with speed sign");

endmodule

bind quadrature_encoder_speed qes_checker u_qes_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .edge_accepted_o    (edge_accepted_o),
  .position_count_o   (position_count_o),
  .speed_value_o      (speed_value_o),
  .motion_direction_o (motion_direction_o),
  .is_stopped_o       (is_stopped_o)
);

>>> test/quadrature_encoder_speed_test.sv
`timescale 1ns / 1ps
module quadrature_encoder_speed_test;
  import qes_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int PHASE_COUNT     = 8;
  localparam int ITEMS_PER_PHASE = 105;
  localparam int REPORT_LIMIT    = 10;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 40;

  typedef struct packed {
    logic               accepted;
    logic [POS_W-1:0]   pos;
    logic [SPEED_W-1:0] speed;
    logic [DIR_W-1:0]   dir;
    logic               stopped;
    logic [DIST_W-1:0]  distance;
  } encoder_report_t;

  typedef struct packed {
    logic              is_setting;
    logic [1:0]        mode;
    logic [TIME_W-1:0] stamp;
    logic              a;
    logic              b;
    logic              ch;
    logic              typed;
    encoder_report_t   rep;
    logic [DPC_W-1:0]  dpc;
    logic [TMO_W-1:0]  tmo;
    logic              inv;
    logic [MAXS_W-1:0] maxs;
  } directed_row_t;

  // Every field zero and the stopped flag set: the state right after reset or a clear.
  localparam encoder_report_t QUIET_REPORT = '{1'b0, 32'd0, 32'd0, 2'd0, 1'b1, 56'd0};
  // One counted step down with zero distance per count: no speed, no distance.
  localparam encoder_report_t STEP_DOWN_NO_DPC =
    '{1'b1, 32'hFFFF_FFFF, 32'd0, 2'd0, 1'b1, 56'd0};

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_idx_i;
  logic [CFG_W-1:0]           cfg_data_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [1:0]                 mode_i;
  logic [TIME_W-1:0]          time_ms_i;
  logic                       pin_a_level_i;
  logic                       pin_b_level_i;
  logic                       edge_channel_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic                       edge_accepted_o;
  logic signed [POS_W-1:0]    position_count_o;
  logic signed [SPEED_W-1:0]  speed_value_o;
  logic signed [DIR_W-1:0]    motion_direction_o;
  logic                       is_stopped_o;
  logic signed [DIST_W-1:0]   distance_value_o;

  quadrature_encoder_speed dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .time_ms_i          (time_ms_i),
    .pin_a_level_i      (pin_a_level_i),
    .pin_b_level_i      (pin_b_level_i),
    .edge_channel_i     (edge_channel_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .edge_accepted_o    (edge_accepted_o),
    .position_count_o   (position_count_o),
    .speed_value_o      (speed_value_o),
    .motion_direction_o (motion_direction_o),
    .is_stopped_o       (is_stopped_o),
    .distance_value_o   (distance_value_o)
  );

  // Encoder state as the block should hold it.
  logic [DPC_W-1:0]   model_dpc  = DPC_RESET;
  logic [TMO_W-1:0]   model_tmo  = TMO_RESET;
  logic               model_inv  = 1'b0;
  logic [MAXS_W-1:0]  model_maxs = MAXS_RESET;
  logic [POS_W-1:0]   step_cnt     = '0;
  logic [SPEED_W-1:0] speed_now    = '0;
  logic [TIME_W-1:0]  last_edge_ms = '0;
  logic [TIME_W-1:0]  interval_hist [HISTORY_DEPTH];

  encoder_report_t pending_reports [$];
  logic            typed_flag;
  encoder_report_t typed_report;

  int unsigned edges_taken, edges_rejected, polls_seen, clears_seen, ignored_seen;
  int unsigned settings_used, results_seen, error_count;
  int unsigned gap_style, stall_style;
  bit          hold_request;

  initial begin
    for (int i = 0; i < HISTORY_DEPTH; i++) interval_hist[i] = '0;
  end

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #6_000_000;
    $display("Run did not finish in time; %0d results still waiting.",
             pending_reports.size());
    $display("quadrature_encoder_speed_test: FAIL");
    $finish;
  end

  function automatic int unsigned idle_len(int unsigned style);
    int unsigned r;
    r = $urandom_range(99);
    if (style == 0) return 0;
    if (style == 2) r = r / 2;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("[%0t] %s", $time, msg);
  endtask

  // Applies one item to the encoder state and returns the report it should produce.
  function automatic encoder_report_t advance_encoder(logic [1:0] mode, logic [TIME_W-1:0] t,
                                                      logic a, logic b, logic ch);
    encoder_report_t   rep;
    logic [TIME_W-1:0] span;
    logic [63:0]       lhs, rhs, total, quo;
    logic              up;
    longint            dist_prod;
    rep = '0;
    span = t - last_edge_ms;
    case (mode)
      MODE_EDGE: begin
        lhs = 64'(model_dpc) * 64'(MS_PER_S);
        rhs = 64'(model_maxs) * 64'(span);
        // Long intervals always pass; otherwise compare in 16-bit fixed point.
        if (rhs >= (64'd1 << RHS_LIM_W) || lhs <= (rhs << DPC_FRAC)) begin
          rep.accepted = 1'b1;
          edges_taken++;
          total = 64'(span);
          for (int i = 0; i < HISTORY_DEPTH; i++) total = total + 64'(interval_hist[i]);
          for (int i = HISTORY_DEPTH - 1; i > 0; i--) interval_hist[i] = interval_hist[i-1];
          interval_hist[0] = span;
          last_edge_ms = t;
          quo = '0;
          if (model_dpc != 0 && total != 0) begin
            quo = (64'(model_dpc) * 64'(SPEED_K)) / (total * 64'd256);
            if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
          end
          up = a ^ b ^ model_inv ^ ch;
          step_cnt  = up ? step_cnt + 1'b1 : step_cnt - 1'b1;
          speed_now = up ? quo[SPEED_W-1:0] : '0 - quo[SPEED_W-1:0];
        end else begin
          edges_rejected++;
        end
      end
      MODE_POLL: begin
        polls_seen++;
        if (span >= TIME_W'(model_tmo)) begin
          speed_now = '0;
          last_edge_ms = t - TIME_W'(model_tmo);
        end
      end
      MODE_CLEAR: begin
        clears_seen++;
        step_cnt  = '0;
        speed_now = '0;
      end
      default: ignored_seen++;
    endcase
    dist_prod = longint'($signed(step_cnt)) * longint'(model_dpc);
    rep.pos      = step_cnt;
    rep.speed    = speed_now;
    rep.dir      = ($signed(speed_now) > 0) ? 2'b01 : (($signed(speed_now) < 0) ? 2'b11 : 2'b00);
    rep.stopped  = (speed_now == '0);
    rep.distance = dist_prod[DIST_W-1:0];
    return rep;
  endfunction

  always @(posedge clk_i) begin : check_results
    encoder_report_t got, want;
    string           diffs;
    if (rst_ni === 1'b1) begin
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        got = {edge_accepted_o, position_count_o, speed_value_o, motion_direction_o,
               is_stopped_o, distance_value_o};
        results_seen++;
        if (pending_reports.size() == 0) begin
          flag_error("Result arrived with no item waiting for it.");
        end else begin
          want = pending_reports.pop_front();
          diffs = "";
          if (got.accepted !== want.accepted) diffs = {diffs, " edge_accepted"};
          if (got.pos      !== want.pos)      diffs = {diffs, " position_count"};
          if (got.speed    !== want.speed)    diffs = {diffs, " speed_value"};
          if (got.dir      !== want.dir)      diffs = {diffs, " motion_direction"};
          if (got.stopped  !== want.stopped)  diffs = {diffs, " is_stopped"};
          if (got.distance !== want.distance) diffs = {diffs, " distance_value"};
          if (diffs != "")
            flag_error($sformatf({"Result %0d differs in%s: expected acc %0d pos %0d spd %0d ",
                                  "dir %0d stop %0d dist %0d, got acc %0d pos %0d spd %0d ",
                                  "dir %0d stop %0d dist %0d"},
                                 results_seen, diffs, want.accepted, $signed(want.pos),
                                 $signed(want.speed), $signed(want.dir), want.stopped,
                                 $signed(want.distance), got.accepted, $signed(got.pos),
                                 $signed(got.speed), $signed(got.dir), got.stopped,
                                 $signed(got.distance)));
        end
      end
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
        want = advance_encoder(mode_i, time_ms_i, pin_a_level_i, pin_b_level_i,
                               edge_channel_i);
        if (typed_flag) want = typed_report;
        pending_reports.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DPC:     model_dpc  = cfg_data_i[DPC_W-1:0];
          CFG_TIMEOUT: model_tmo  = cfg_data_i[TMO_W-1:0];
          CFG_INVERT:  model_inv  = cfg_data_i[0];
          CFG_MAXS:    model_maxs = cfg_data_i[MAXS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Output side: random stalls, plus one long hold-off when the sender asks for it.
  initial begin : receiver
    logic        level;
    int unsigned run;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        level = 1'b1;
        run = HOLD_CYCLES;
      end else if (stall_style == 0) begin
        level = 1'b0;
        run = 1;
      end else begin
        level = ($urandom_range(99) < ((stall_style == 2) ? 50 : 25));
        run = 1 + idle_len(stall_style);
      end
      out_stall_i <= level;
      repeat (run) @(posedge clk_i);
    end
  end

  task automatic offer_item(input logic [1:0] mode, input logic [TIME_W-1:0] stamp,
                            input logic a, input logic b, input logic ch,
                            input logic typed, input encoder_report_t rep,
                            input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    time_ms_i      <= stamp;
    pin_a_level_i  <= a;
    pin_b_level_i  <= b;
    edge_channel_i <= ch;
    typed_flag     <= typed;
    typed_report   <= rep;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [DPC_W-1:0] dpc, input logic [TMO_W-1:0] tmo,
                                input logic inv, input logic [MAXS_W-1:0] maxs);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DPC;
    cfg_data_i <= CFG_W'(dpc);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_TIMEOUT;
    cfg_data_i <= CFG_W'(tmo);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_INVERT;
    cfg_data_i <= CFG_W'(inv);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAXS;
    cfg_data_i <= CFG_W'(maxs);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  function automatic directed_row_t item_row(logic [1:0] mode, logic [TIME_W-1:0] stamp,
                                             logic a, logic b, logic ch);
    directed_row_t row;
    row = '0;
    row.mode  = mode;
    row.stamp = stamp;
    row.a     = a;
    row.b     = b;
    row.ch    = ch;
    return row;
  endfunction

  function automatic directed_row_t typed_row(logic [1:0] mode, logic [TIME_W-1:0] stamp,
                                              logic a, logic b, logic ch,
                                              encoder_report_t rep);
    directed_row_t row;
    row = item_row(mode, stamp, a, b, ch);
    row.typed = 1'b1;
    row.rep   = rep;
    return row;
  endfunction

  function automatic directed_row_t setting_row(logic [DPC_W-1:0] dpc, logic [TMO_W-1:0] tmo,
                                                logic inv, logic [MAXS_W-1:0] maxs);
    directed_row_t row;
    row = '0;
    row.is_setting = 1'b1;
    row.dpc  = dpc;
    row.tmo  = tmo;
    row.inv  = inv;
    row.maxs = maxs;
    return row;
  endfunction

  initial begin : stimulus
    directed_row_t     rows [$];
    logic [TIME_W-1:0] stamp;
    logic [63:0]       need, cap;
    logic [DPC_W-1:0]  ph_dpc;
    logic [TMO_W-1:0]  ph_tmo;
    logic              ph_inv;
    logic [MAXS_W-1:0] ph_maxs;
    logic [1:0]        kind;
    int unsigned       r;

    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    mode_i         <= MODE_EDGE;
    time_ms_i      <= '0;
    pin_a_level_i  <= 1'b0;
    pin_b_level_i  <= 1'b0;
    edge_channel_i <= 1'b0;
    typed_flag     <= 1'b0;
    typed_report   <= QUIET_REPORT;
    gap_style      = 0;
    stall_style    = 0;
    hold_request   = 1'b0;

    // Defaults: distance per count 1.0, timeout 100 ms, max speed 100.
    rows.push_back(typed_row(MODE_POLL,   32'd0, 1'b0, 1'b0, 1'b0, QUIET_REPORT));
    rows.push_back(typed_row(MODE_UNUSED, 32'd5, 1'b1, 1'b1, 1'b1, QUIET_REPORT));
    // A zero interval is a glitch while distance per count is nonzero.
    rows.push_back(typed_row(MODE_EDGE,   32'd0, 1'b0, 1'b0, 1'b0, QUIET_REPORT));
    rows.push_back(item_row(MODE_EDGE, 32'd1000, 1'b1, 1'b0, 1'b0));
    // Ten milliseconds sits exactly on the glitch limit and passes; nine does not.
    rows.push_back(item_row(MODE_EDGE, 32'd1010, 1'b0, 1'b0, 1'b0));
    rows.push_back(item_row(MODE_EDGE, 32'd1019, 1'b1, 1'b1, 1'b0));
    rows.push_back(item_row(MODE_EDGE, 32'd1100, 1'b1, 1'b1, 1'b1));
    rows.push_back(item_row(MODE_POLL, 32'd1150, 1'b0, 1'b0, 1'b0));
    rows.push_back(item_row(MODE_POLL, 32'd1300, 1'b0, 1'b0, 1'b0));
    rows.push_back(typed_row(MODE_CLEAR, 32'd1400, 1'b1, 1'b0, 1'b1, QUIET_REPORT));
    rows.push_back(item_row(MODE_EDGE,   32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1));
    rows.push_back(item_row(MODE_UNUSED, 32'h8000_0000, 1'b0, 1'b0, 1'b0));
    rows.push_back(setting_row('1, '0, 1'b1, '1));
    rows.push_back(item_row(MODE_EDGE, 32'h0000_0010, 1'b0, 1'b1, 1'b0));
    rows.push_back(item_row(MODE_POLL, 32'h0000_0010, 1'b1, 1'b1, 1'b1));
    rows.push_back(item_row(MODE_EDGE, 32'h0010_0000, 1'b1, 1'b1, 1'b0));
    // No distance per count: any interval counts, the speed stays zero.
    rows.push_back(setting_row('0, '1, 1'b1, '0));
    rows.push_back(typed_row(MODE_CLEAR, 32'h0000_0020, 1'b0, 1'b0, 1'b0, QUIET_REPORT));
    rows.push_back(typed_row(MODE_EDGE, 32'h0010_0000, 1'b1, 1'b0, 1'b0, STEP_DOWN_NO_DPC));
    rows.push_back(item_row(MODE_EDGE, 32'h0010_0000, 1'b0, 1'b0, 1'b1));
    // Max speed zero turns every edge into a glitch.
    rows.push_back(setting_row(24'd1, '1, 1'b0, '0));
    rows.push_back(item_row(MODE_EDGE, 32'h0010_0100, 1'b1, 1'b0, 1'b0));
    rows.push_back(item_row(MODE_POLL, 32'h0020_0000, 1'b0, 1'b0, 1'b0));
    rows.push_back(setting_row(DPC_RESET, TMO_RESET, 1'b0, MAXS_RESET));
    rows.push_back(item_row(MODE_EDGE, 32'h0020_0400, 1'b0, 1'b1, 1'b1));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_setting) begin
        drain_results();
        apply_settings(rows[i].dpc, rows[i].tmo, rows[i].inv, rows[i].maxs);
      end else begin
        offer_item(rows[i].mode, rows[i].stamp, rows[i].a, rows[i].b, rows[i].ch,
                   rows[i].typed, rows[i].rep, 0);
      end
    end

    stamp = 32'h0030_0000;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_results();
      if (p == 0) begin
        ph_dpc = '1; ph_tmo = '1; ph_inv = 1'b1; ph_maxs = 16'd1;
      end else if (p == 1) begin
        ph_dpc = 24'd1; ph_tmo = '0; ph_inv = 1'b0; ph_maxs = '1;
      end else begin
        r = $urandom_range(9);
        ph_dpc = (r == 0) ? '0 : (r == 1) ? 24'd1 : (r == 2) ? '1 :
                 (r < 7) ? DPC_W'($urandom_range(256, 262144)) : DPC_W'($urandom);
        r = $urandom_range(9);
        ph_tmo = (r == 0) ? '0 : (r == 1) ? '1 : TMO_W'($urandom_range(20, 300));
        r = $urandom_range(9);
        ph_maxs = (r == 0) ? 16'd1 : (r == 1) ? '1 :
                  (r < 6) ? MAXS_W'($urandom_range(50, 2000)) : MAXS_W'($urandom_range(1, 65535));
        ph_inv = $urandom_range(1);
      end
      apply_settings(ph_dpc, ph_tmo, ph_inv, ph_maxs);
      gap_style   = $urandom_range(2);
      stall_style = $urandom_range(2);
      // Shortest interval that clears the glitch check under this setting.
      need = (64'(ph_dpc) * 64'(MS_PER_S) + 64'(ph_maxs) * 64'd65536 - 64'd1) /
             (64'(ph_maxs) * 64'd65536);
      cap = (64'd1 << RHS_LIM_W) / 64'(ph_maxs) + 64'd1;
      if (need > cap) need = cap;
      if ($urandom_range(3) == 0) stamp = 32'hFFFF_FFFF - TIME_W'($urandom_range(5000));

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(99);
        kind = (r < 72) ? MODE_EDGE : (r < 86) ? MODE_POLL : (r < 94) ? MODE_CLEAR : MODE_UNUSED;
        r = $urandom_range(99);
        case (kind)
          MODE_EDGE: begin
            if (r < 8) stamp = stamp;
            else if (r < 20) stamp = stamp + ((need != 0) ? TIME_W'(need - 1) : '0);
            else if (r < 65) stamp = stamp + TIME_W'(need) + TIME_W'($urandom_range(20));
            else if (r < 92) stamp = stamp + TIME_W'(need) + TIME_W'($urandom_range(ph_tmo + 50));
            else stamp = $urandom;
          end
          MODE_POLL: begin
            if (r < 50) stamp = stamp + TIME_W'($urandom_range(ph_tmo));
            else stamp = stamp + TIME_W'(ph_tmo) + TIME_W'($urandom_range(100));
          end
          default: stamp = stamp + TIME_W'($urandom_range(10));
        endcase
        // Mid-run, the receiver holds off long enough for the input side to back up.
        if (p == 2 && n == 30) hold_request = 1'b1;
        offer_item(kind, stamp, $urandom_range(1), $urandom_range(1), $urandom_range(1),
                   1'b0, QUIET_REPORT, idle_len(gap_style));
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_reports.size() != 0)
      flag_error($sformatf("%0d expected results never arrived.", pending_reports.size()));
    $display("Covered %0d edges counted, %0d glitches, %0d polls, %0d clears, %0d ignored.",
             edges_taken, edges_rejected, polls_seen, clears_seen, ignored_seen);
    $display("Checked %0d results under %0d register settings; %0d errors.",
             results_seen, settings_used, error_count);
    if (error_count == 0) begin
      $display("quadrature_encoder_speed_test: PASS");
    end else begin
      $display("quadrature_encoder_speed_test: FAIL");
    end
    $finish;
  end

endmodule

>>> quadrature_encoder_speed.f
sv/qes_pkg.sv
sv/qes_div.sv
sv/qes_datapath.sv
sv/qes_ctrl.sv
sv/quadrature_encoder_speed.sv
sv/qes_checker.sv
test/quadrature_encoder_speed_test.sv
